[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside of reset.
`define ASSERT_CLOCKED(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("udp_socket_demux assertion failed");

// Property checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("udp_socket_demux assertion failed");

`endif

[rtl/core/udp_sd_pkg.sv]
// Package with the types, constants and codes of the UDP socket demultiplexer.
`timescale 1ns / 1ps

package udp_sd_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [15:0] HDR_BYTES = 16'd8;

   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_CLEAR = 2'd1;
   localparam logic [1:0] FUNC_LOOKUP = 2'd2;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOLISTEN = 2'd1,
      ST_BAD      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_WRITE,
      CMD_CLEAR,
      CMD_LOOKUP,
      CMD_BAD
   } cmd_kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_SCAN
   } back_state_type;

   typedef struct packed {
      logic [31:0] dst_addr;
      logic [15:0] dst_port;
      logic [31:0] src_addr;
      logic [15:0] src_port;
      logic        connected;
   } entry_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   slot;
      entry_type    ent;
      logic [15:0]  plen;
   } cmd_type;

endpackage

[rtl/core/udp_socket_demux.sv]
// Top level of the UDP socket demultiplexer.
//
//   channel   direction   handshake            contents
//   req_      in          req_valid/req_ready   write, clear or lookup request
//   rsp_      out         rsp_valid/rsp_ready   status, match slot, payload length
//
// The front end classifies a request in the cycle it is accepted and queues it
// (two entries). A write, clear or rejected lookup is done by the table engine
// straight from its idle state; a lookup scans the table slot by slot and ends
// early on a connected match, reading the table RAM one slot per cycle.
// Reset clears all slot valid bits at once; no clearing pass is needed.
// A stalled response holds the engine, while requests still fill the queue.
`timescale 1ns / 1ps

module udp_socket_demux (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [3:0]  req_slot,
   input  logic [31:0] req_dst_addr,
   input  logic [15:0] req_dst_port,
   input  logic [31:0] req_src_addr,
   input  logic [15:0] req_src_port,
   input  logic        req_connected,
   input  logic [15:0] req_packet_length,
   input  logic [15:0] req_header_length,
   input  logic [15:0] req_header_checksum,
   input  logic        req_pseudo_sum_ok,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_match_slot,
   output logic [15:0] rsp_payload_length
);

   logic room;
   logic push;
   udp_sd_pkg::cmd_type push_cmd;
   logic q_valid;
   udp_sd_pkg::cmd_type q_cmd;
   logic q_pop;

   udp_sd_front u_front (
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_slot(req_slot),
      .req_dst_addr(req_dst_addr),
      .req_dst_port(req_dst_port),
      .req_src_addr(req_src_addr),
      .req_src_port(req_src_port),
      .req_connected(req_connected),
      .req_packet_length(req_packet_length),
      .req_header_length(req_header_length),
      .req_header_checksum(req_header_checksum),
      .req_pseudo_sum_ok(req_pseudo_sum_ok),
      .room(room),
      .push(push),
      .push_cmd(push_cmd)
   );

   udp_sd_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_cmd(push_cmd),
      .room(room),
      .q_valid(q_valid),
      .q_cmd(q_cmd),
      .pop(q_pop)
   );

   udp_sd_back u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_cmd(q_cmd),
      .q_pop(q_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_match_slot(rsp_match_slot),
      .rsp_payload_length(rsp_payload_length)
   );

endmodule

[rtl/core/udp_sd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module udp_sd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/udp_sd_front.sv]
// Front end: checks and classifies each request and hands it to the command queue.
`timescale 1ns / 1ps

module udp_sd_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_func,
   input  logic [3:0]           req_slot,
   input  logic [31:0]          req_dst_addr,
   input  logic [15:0]          req_dst_port,
   input  logic [31:0]          req_src_addr,
   input  logic [15:0]          req_src_port,
   input  logic                 req_connected,
   input  logic [15:0]          req_packet_length,
   input  logic [15:0]          req_header_length,
   input  logic [15:0]          req_header_checksum,
   input  logic                 req_pseudo_sum_ok,
   input  logic                 room,
   output logic                 push,
   output udp_sd_pkg::cmd_type  push_cmd
);

   logic in_range;
   logic malformed;

   always_comb begin
      in_range = 32'(req_slot) < 32'(udp_sd_pkg::NUM_SLOTS);
      malformed = (req_packet_length < udp_sd_pkg::HDR_BYTES) ||
                  (req_header_length < udp_sd_pkg::HDR_BYTES) ||
                  (req_header_length > req_packet_length) ||
                  ((req_header_checksum != 16'd0) && !req_pseudo_sum_ok);

      push_cmd.slot = req_slot;
      push_cmd.ent.dst_addr = req_dst_addr;
      push_cmd.ent.dst_port = req_dst_port;
      push_cmd.ent.src_addr = req_src_addr;
      push_cmd.ent.src_port = req_src_port;
      push_cmd.ent.connected = req_connected;
      push_cmd.plen = req_header_length - udp_sd_pkg::HDR_BYTES;

      // Writes and clears to slots past the table turn into no-ops here.
      case (req_func)
         udp_sd_pkg::FUNC_WRITE: begin
            push_cmd.kind = in_range ? udp_sd_pkg::CMD_WRITE : udp_sd_pkg::CMD_NOP;
         end
         udp_sd_pkg::FUNC_CLEAR: begin
            push_cmd.kind = in_range ? udp_sd_pkg::CMD_CLEAR : udp_sd_pkg::CMD_NOP;
         end
         udp_sd_pkg::FUNC_LOOKUP: begin
            push_cmd.kind = malformed ? udp_sd_pkg::CMD_BAD : udp_sd_pkg::CMD_LOOKUP;
         end
         default: begin
            push_cmd.kind = udp_sd_pkg::CMD_NOP;
         end
      endcase
   end

   assign req_ready = room;
   assign push = req_valid && room;

endmodule

[rtl/core/udp_sd_fifo.sv]
// Short command queue between the front end and the table engine.
`timescale 1ns / 1ps

module udp_sd_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  udp_sd_pkg::cmd_type push_cmd,
   output logic                room,
   output logic                q_valid,
   output udp_sd_pkg::cmd_type q_cmd,
   input  logic                pop
);

   udp_sd_pkg::cmd_type mem_ff [udp_sd_pkg::QUEUE_DEPTH];
   logic [udp_sd_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [udp_sd_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [udp_sd_pkg::QCNT_W-1:0] count_ff, count_in;

   localparam logic [udp_sd_pkg::QPTR_W-1:0] LAST_PTR =
      udp_sd_pkg::QPTR_W'(udp_sd_pkg::QUEUE_DEPTH - 1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + udp_sd_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + udp_sd_pkg::QPTR_W'(1);
      end
      case ({push, pop})
         2'b10: count_in = count_ff + udp_sd_pkg::QCNT_W'(1);
         2'b01: count_in = count_ff - udp_sd_pkg::QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign room = count_ff != udp_sd_pkg::QCNT_W'(udp_sd_pkg::QUEUE_DEPTH);
   assign q_valid = count_ff != '0;
   assign q_cmd = mem_ff[rd_ptr_ff];

endmodule

[rtl/core/udp_sd_back.sv]
// Table engine: stores endpoints, scans the table for lookups and holds the response.
`timescale 1ns / 1ps

module udp_sd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  udp_sd_pkg::cmd_type q_cmd,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [3:0]          rsp_match_slot,
   output logic [15:0]         rsp_payload_length
);

   localparam int IW = udp_sd_pkg::IDX_W;
   localparam int EW = $bits(udp_sd_pkg::entry_type);
   localparam logic [IW-1:0] LAST_IDX = IW'(udp_sd_pkg::NUM_SLOTS - 1);

   udp_sd_pkg::back_state_type state_ff, state_in;
   logic [udp_sd_pkg::NUM_SLOTS-1:0] valid_ff, valid_in;
   logic [IW-1:0] iss_ff, iss_in;
   logic iss_on_ff, iss_on_in;
   logic cmp_on_ff, cmp_on_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;
   logic found_ff, found_in;
   logic [IW-1:0] pick_ff, pick_in;
   udp_sd_pkg::entry_type key_ff, key_in;
   logic [15:0] plen_ff, plen_in;
   logic rsp_valid_ff, rsp_valid_in;
   udp_sd_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [3:0] rsp_slot_ff, rsp_slot_in;
   logic [15:0] rsp_len_ff, rsp_len_in;

   logic ram_we;
   logic [IW-1:0] wr_idx;
   logic [EW-1:0] ram_rdata;
   udp_sd_pkg::entry_type rd_ent;

   logic out_free;
   logic cmp_match, conn_hit, unc_hit, scan_done, res_found;
   logic [IW-1:0] res_pick;

   assign wr_idx = IW'(q_cmd.slot);

   udp_sd_ram #(
      .WIDTH(EW),
      .DEPTH(udp_sd_pkg::NUM_SLOTS)
   ) u_table (
      .clock(clock),
      .we(ram_we),
      .waddr(wr_idx),
      .wdata(EW'(q_cmd.ent)),
      .raddr(iss_ff),
      .rdata(ram_rdata)
   );

   assign rd_ent = udp_sd_pkg::entry_type'(ram_rdata);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Compare stage: the entry read last cycle against the packet's endpoints.
   always_comb begin
      cmp_match = cmp_on_ff && valid_ff[cmp_idx_ff] &&
                  (rd_ent.dst_port == key_ff.dst_port) &&
                  ((rd_ent.dst_addr == 32'd0) ||
                   (rd_ent.dst_addr == key_ff.dst_addr));
      conn_hit = cmp_match && rd_ent.connected &&
                 (rd_ent.src_addr == key_ff.src_addr) &&
                 (rd_ent.src_port == key_ff.src_port);
      unc_hit = cmp_match && !rd_ent.connected && !found_ff;
      scan_done = cmp_on_ff && (conn_hit || (cmp_idx_ff == LAST_IDX));
      res_found = conn_hit || found_ff || unc_hit;
      res_pick = (conn_hit || !found_ff) ? cmp_idx_ff : pick_ff;
   end

   always_comb begin
      case (state_ff)
         udp_sd_pkg::BK_IDLE: begin
            if (q_valid && out_free && (q_cmd.kind == udp_sd_pkg::CMD_LOOKUP)) begin
               state_in = udp_sd_pkg::BK_SCAN;
            end else begin
               state_in = udp_sd_pkg::BK_IDLE;
            end
         end
         udp_sd_pkg::BK_SCAN: begin
            state_in = scan_done ? udp_sd_pkg::BK_IDLE : udp_sd_pkg::BK_SCAN;
         end
         default: begin
            state_in = udp_sd_pkg::BK_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      iss_in = iss_ff;
      iss_on_in = iss_on_ff;
      cmp_on_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      found_in = found_ff;
      pick_in = pick_ff;
      key_in = key_ff;
      plen_in = plen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in = rsp_slot_ff;
      rsp_len_in = rsp_len_ff;
      q_pop = 1'b0;
      ram_we = 1'b0;

      case (state_ff)
         udp_sd_pkg::BK_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               rsp_slot_in = 4'd0;
               rsp_len_in = 16'd0;
               rsp_status_in = udp_sd_pkg::ST_OK;
               rsp_valid_in = 1'b1;
               case (q_cmd.kind)
                  udp_sd_pkg::CMD_WRITE: begin
                     ram_we = 1'b1;
                     valid_in[wr_idx] = 1'b1;
                  end
                  udp_sd_pkg::CMD_CLEAR: begin
                     valid_in[wr_idx] = 1'b0;
                  end
                  udp_sd_pkg::CMD_BAD: begin
                     rsp_status_in = udp_sd_pkg::ST_BAD;
                  end
                  udp_sd_pkg::CMD_LOOKUP: begin
                     // The response comes at the end of the scan.
                     rsp_valid_in = 1'b0;
                     key_in = q_cmd.ent;
                     plen_in = q_cmd.plen;
                     iss_in = '0;
                     iss_on_in = 1'b1;
                     found_in = 1'b0;
                     pick_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         udp_sd_pkg::BK_SCAN: begin
            if (iss_on_ff) begin
               cmp_on_in = 1'b1;
               cmp_idx_in = iss_ff;
               if (iss_ff == LAST_IDX) begin
                  iss_on_in = 1'b0;
               end else begin
                  iss_in = iss_ff + IW'(1);
               end
            end
            if (unc_hit) begin
               found_in = 1'b1;
               pick_in = cmp_idx_ff;
            end
            if (scan_done) begin
               iss_on_in = 1'b0;
               cmp_on_in = 1'b0;
               rsp_valid_in = 1'b1;
               if (res_found) begin
                  rsp_status_in = udp_sd_pkg::ST_OK;
                  rsp_slot_in = 4'(res_pick);
                  rsp_len_in = plen_ff;
               end else begin
                  rsp_status_in = udp_sd_pkg::ST_NOLISTEN;
                  rsp_slot_in = 4'd0;
                  rsp_len_in = 16'd0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= udp_sd_pkg::BK_IDLE;
         valid_ff <= '0;
         iss_on_ff <= 1'b0;
         cmp_on_ff <= 1'b0;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         iss_on_ff <= iss_on_in;
         cmp_on_ff <= cmp_on_in;
         found_ff <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_ff <= iss_in;
      cmp_idx_ff <= cmp_idx_in;
      pick_ff <= pick_in;
      key_ff <= key_in;
      plen_ff <= plen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_len_ff <= rsp_len_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_match_slot = rsp_slot_ff;
   assign rsp_payload_length = rsp_len_ff;

endmodule

[rtl/core/udp_sd_checker.sv]
// Port-level checker for the UDP socket demultiplexer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module udp_sd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [3:0]  rsp_match_slot,
   input logic [15:0] rsp_payload_length
);

   logic        rsp_stall;
   logic [21:0] rsp_word;
   logic        status_known;
   logic        dropped;
   logic        fields_zero;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word = {rsp_status, rsp_match_slot, rsp_payload_length};
   assign status_known = (rsp_status == udp_sd_pkg::ST_OK) ||
                         (rsp_status == udp_sd_pkg::ST_NOLISTEN) ||
                         (rsp_status == udp_sd_pkg::ST_BAD);
   assign dropped = rsp_valid && (rsp_status != udp_sd_pkg::ST_OK);
   assign fields_zero = (rsp_match_slot == 4'd0) && (rsp_payload_length == 16'd0);

   // A stalled response keeps its contents.
   `ASSERT_CLOCKED(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid && $stable(rsp_word))

   // Only the three defined status codes ever leave the block.
   `ASSERT_CLOCKED(a_status_code, clock, reset, rsp_valid |-> status_known)

   // Dropped datagrams carry no slot and no length.
   `ASSERT_CLOCKED(a_drop_zero, clock, reset, dropped |-> fields_zero)

   // No response is pending right after reset.
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind udp_socket_demux udp_sd_checker u_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_status(rsp_status),
   .rsp_match_slot(rsp_match_slot),
   .rsp_payload_length(rsp_payload_length)
);
